### hw/rtl/occupancy_sitting_time_monitor_assert.svh
// Assertion macros for the occupancy sitting-time monitor.
`ifndef OCCUPANCY_SITTING_TIME_MONITOR_ASSERT_SVH
`define OCCUPANCY_SITTING_TIME_MONITOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OSTM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("occupancy monitor check failed");

// Next-cycle implication, checked out of reset.
`define OSTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("occupancy monitor check failed");

`endif

### hw/rtl/ostm_pkg.sv
// Types and constants shared by the occupancy sitting-time monitor.
package ostm_pkg;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_SITTING = 2'd1,
        MODE_LONG    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_SAMPLE       = 2'd0,
        FUNC_TAKE_CHANGED = 2'd1,
        FUNC_TAKE_REPORT  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_PRESENCE_CONFIRM = 2'd0,
        CFG_ABSENCE_CONFIRM  = 2'd1,
        CFG_SITTING_LIMIT    = 2'd2,
        CFG_REPORT_INTERVAL  = 2'd3
    } cfg_index_t;

    localparam int RUN_W   = 16;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 32;

    localparam logic [RUN_W-1:0]   PRESENCE_CONFIRM_RST = 16'd3;
    localparam logic [RUN_W-1:0]   ABSENCE_CONFIRM_RST  = 16'd5;
    localparam logic [COUNT_W-1:0] SITTING_LIMIT_RST    = 32'd1800;
    localparam logic [COUNT_W-1:0] REPORT_INTERVAL_RST  = 32'd60;
    localparam logic [COUNT_W-1:0] COUNT_SAT            = 32'hFFFF_FFFF;

endpackage

### hw/rtl/occupancy_sitting_time_monitor.sv
// Occupancy sitting-time monitor: presence debounce, sitting timer and sticky flags.
//
//  channel | ports              | handshake       | payload
//  --------+--------------------+-----------------+------------------------------------
//  input   | s_*                | s_valid/s_ready | s_func, s_present_sample
//  result  | m_*                | m_valid/m_ready | state, occupied, alarm, seconds, flag
//  config  | cfg_*              | cfg_we          | cfg_index, cfg_wdata
//
// One item per cycle sustained unless the result stalls; each item goes from the input
// register through one pass of compare/increment logic into the result register.
// Synchronous active-low reset returns valid, state and config registers to defaults.
// A stalled result holds in the output register while one more item waits in the
// input register; s_ready drops only when both are full.
module occupancy_sitting_time_monitor (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic        s_present_sample,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_occupancy_state,
    output logic        m_occupied,
    output logic        m_alarm_on,
    output logic [31:0] m_seconds_sitting,
    output logic        m_taken_flag,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // Configuration
    logic [ostm_pkg::RUN_W-1:0]   presence_confirm_reg;
    logic [ostm_pkg::RUN_W-1:0]   absence_confirm_reg;
    logic [ostm_pkg::COUNT_W-1:0] sitting_limit_reg;
    logic [ostm_pkg::COUNT_W-1:0] report_interval_reg;

    // Input stage
    logic                in_valid_reg;
    ostm_pkg::func_t     in_func_reg;
    logic                in_sample_reg;

    // Monitor state
    ostm_pkg::mode_t              mode_reg, mode_next;
    logic                         present_reg, present_next;
    logic                         alarm_reg, alarm_next;
    logic [ostm_pkg::RUN_W-1:0]   presence_run_reg, presence_run_next;
    logic [ostm_pkg::RUN_W-1:0]   absence_run_reg, absence_run_next;
    logic [ostm_pkg::COUNT_W-1:0] sitting_reg, sitting_next;
    logic [ostm_pkg::COUNT_W-1:0] report_reg, report_next;
    logic                         changed_reg, changed_next;
    logic                         taken_next;

    // Result stage
    logic                         out_valid_reg;
    ostm_pkg::mode_t              out_mode_reg;
    logic                         out_occupied_reg;
    logic                         out_alarm_reg;
    logic [ostm_pkg::COUNT_W-1:0] out_seconds_reg;
    logic                         out_taken_reg;

    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presence_confirm_reg <= ostm_pkg::PRESENCE_CONFIRM_RST;
            absence_confirm_reg  <= ostm_pkg::ABSENCE_CONFIRM_RST;
            sitting_limit_reg    <= ostm_pkg::SITTING_LIMIT_RST;
            report_interval_reg  <= ostm_pkg::REPORT_INTERVAL_RST;
        end else if (cfg_we) begin
            case (ostm_pkg::cfg_index_t'(cfg_index))
                ostm_pkg::CFG_PRESENCE_CONFIRM: begin
                    presence_confirm_reg <= cfg_wdata[ostm_pkg::RUN_W-1:0];
                end
                ostm_pkg::CFG_ABSENCE_CONFIRM: begin
                    absence_confirm_reg <= cfg_wdata[ostm_pkg::RUN_W-1:0];
                end
                ostm_pkg::CFG_SITTING_LIMIT: begin
                    sitting_limit_reg <= cfg_wdata;
                end
                ostm_pkg::CFG_REPORT_INTERVAL: begin
                    report_interval_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg   <= ostm_pkg::func_t'(s_func);
            in_sample_reg <= s_present_sample;
        end
    end

    always_comb begin
        mode_next         = mode_reg;
        present_next      = present_reg;
        alarm_next        = alarm_reg;
        presence_run_next = presence_run_reg;
        absence_run_next  = absence_run_reg;
        sitting_next      = sitting_reg;
        report_next       = report_reg;
        changed_next      = changed_reg;
        taken_next        = 1'b0;
        case (in_func_reg)
            ostm_pkg::FUNC_SAMPLE: begin
                if (in_sample_reg) begin
                    absence_run_next = '0;
                    if (presence_run_reg < presence_confirm_reg) begin
                        presence_run_next = presence_run_reg + 16'd1;
                    end
                    if (!present_reg && presence_run_next >= presence_confirm_reg) begin
                        present_next = 1'b1;
                        sitting_next = '0;
                        report_next  = '0;
                        alarm_next   = 1'b0;
                        mode_next    = ostm_pkg::MODE_SITTING;
                        changed_next = 1'b1;
                    end
                end else begin
                    presence_run_next = '0;
                    if (absence_run_reg < absence_confirm_reg) begin
                        absence_run_next = absence_run_reg + 16'd1;
                    end
                    if (present_reg && absence_run_next >= absence_confirm_reg) begin
                        present_next = 1'b0;
                        sitting_next = '0;
                        report_next  = '0;
                        alarm_next   = 1'b0;
                        mode_next    = ostm_pkg::MODE_NONE;
                        changed_next = 1'b1;
                    end
                end
                // Count the second only while presence is confirmed
                if (present_next) begin
                    if (sitting_next != ostm_pkg::COUNT_SAT) begin
                        sitting_next = sitting_next + 32'd1;
                    end
                    if (report_next != ostm_pkg::COUNT_SAT) begin
                        report_next = report_next + 32'd1;
                    end
                    if (!alarm_next && sitting_next >= sitting_limit_reg) begin
                        alarm_next   = 1'b1;
                        mode_next    = ostm_pkg::MODE_LONG;
                        changed_next = 1'b1;
                    end
                end
            end
            ostm_pkg::FUNC_TAKE_CHANGED: begin
                taken_next   = changed_reg;
                changed_next = 1'b0;
            end
            ostm_pkg::FUNC_TAKE_REPORT: begin
                if (report_reg >= report_interval_reg) begin
                    report_next = '0;
                    taken_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= ostm_pkg::MODE_NONE;
            present_reg      <= 1'b0;
            alarm_reg        <= 1'b0;
            presence_run_reg <= '0;
            absence_run_reg  <= '0;
            sitting_reg      <= '0;
            report_reg       <= '0;
            changed_reg      <= 1'b0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            present_reg      <= present_next;
            alarm_reg        <= alarm_next;
            presence_run_reg <= presence_run_next;
            absence_run_reg  <= absence_run_next;
            sitting_reg      <= sitting_next;
            report_reg       <= report_next;
            changed_reg      <= changed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg     <= mode_next;
            out_occupied_reg <= present_next;
            out_alarm_reg    <= alarm_next;
            out_seconds_reg  <= sitting_next;
            out_taken_reg    <= taken_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_occupancy_state = out_mode_reg;
    assign m_occupied        = out_occupied_reg;
    assign m_alarm_on        = out_alarm_reg;
    assign m_seconds_sitting = out_seconds_reg;
    assign m_taken_flag      = out_taken_reg;

`include "occupancy_sitting_time_monitor_assert.svh"

    `OSTM_ASSERT_NOW(a_alarm_needs_presence, alarm_reg, present_reg)
    `OSTM_ASSERT_NOW(a_long_mode_matches_alarm, 1'b1, (mode_reg == ostm_pkg::MODE_LONG) == alarm_reg)
    `OSTM_ASSERT_NOW(a_idle_timers_clear, !present_reg, (sitting_reg == '0) && (report_reg == '0))
    `OSTM_ASSERT_NEXT(a_presence_change_flags, advance && (present_next != present_reg), changed_reg)

endmodule

### tb/occupancy_status_checker.sv
// Checker for the occupancy monitor: mirrors its state, predicts each status item and compares.
module occupancy_status_checker
    import ostm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic               s_present_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_occupancy_state,
    input  logic               m_occupied,
    input  logic               m_alarm_on,
    input  logic [COUNT_W-1:0] m_seconds_sitting,
    input  logic               m_taken_flag,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output int                 mismatch_count,
    output int                 statuses_owed
);

    typedef struct packed {
        logic [1:0]         state;
        logic               occupied;
        logic               alarm;
        logic [COUNT_W-1:0] seconds;
        logic               taken;
    } status_t;

    logic [RUN_W-1:0]   presence_need;
    logic [RUN_W-1:0]   absence_need;
    logic [COUNT_W-1:0] sitting_limit;
    logic [COUNT_W-1:0] report_interval;

    mode_t              mode;
    logic               present;
    logic               alarm;
    logic               changed;
    logic [RUN_W-1:0]   presence_run;
    logic [RUN_W-1:0]   absence_run;
    logic [COUNT_W-1:0] sitting_secs;
    logic [COUNT_W-1:0] report_secs;

    status_t owed_q[$];
    int      mismatches;

    function automatic void restart_session();
        sitting_secs = '0;
        report_secs  = '0;
        alarm        = 1'b0;
    endfunction

    // Apply one item to the mirrored state and return the status it should produce.
    function automatic status_t advance_monitor(logic [1:0] func, logic here);
        status_t s;
        logic    taken;
        taken = 1'b0;
        case (func)
            FUNC_SAMPLE: begin
                if (here) begin
                    absence_run = '0;
                    if (presence_run < presence_need)
                        presence_run = presence_run + 16'd1;
                    if (!present && presence_run >= presence_need) begin
                        present = 1'b1;
                        restart_session();
                        mode    = MODE_SITTING;
                        changed = 1'b1;
                    end
                end else begin
                    presence_run = '0;
                    if (absence_run < absence_need)
                        absence_run = absence_run + 16'd1;
                    if (present && absence_run >= absence_need) begin
                        present = 1'b0;
                        restart_session();
                        mode    = MODE_NONE;
                        changed = 1'b1;
                    end
                end
                if (present) begin
                    if (sitting_secs != COUNT_SAT)
                        sitting_secs = sitting_secs + 32'd1;
                    if (report_secs != COUNT_SAT)
                        report_secs = report_secs + 32'd1;
                    if (!alarm && sitting_secs >= sitting_limit) begin
                        alarm   = 1'b1;
                        mode    = MODE_LONG;
                        changed = 1'b1;
                    end
                end
            end
            FUNC_TAKE_CHANGED: begin
                taken   = changed;
                changed = 1'b0;
            end
            FUNC_TAKE_REPORT: begin
                if (report_secs >= report_interval) begin
                    report_secs = '0;
                    taken       = 1'b1;
                end
            end
            default: ;
        endcase
        s.state    = mode;
        s.occupied = present;
        s.alarm    = alarm;
        s.seconds  = sitting_secs;
        s.taken    = taken;
        return s;
    endfunction

    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (!aresetn) begin
            presence_need   = PRESENCE_CONFIRM_RST;
            absence_need    = ABSENCE_CONFIRM_RST;
            sitting_limit   = SITTING_LIMIT_RST;
            report_interval = REPORT_INTERVAL_RST;
            mode            = MODE_NONE;
            present         = 1'b0;
            alarm           = 1'b0;
            changed         = 1'b0;
            presence_run    = '0;
            absence_run     = '0;
            sitting_secs    = '0;
            report_secs     = '0;
            mismatches      = 0;
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRESENCE_CONFIRM: presence_need   = cfg_wdata[RUN_W-1:0];
                    CFG_ABSENCE_CONFIRM:  absence_need    = cfg_wdata[RUN_W-1:0];
                    CFG_SITTING_LIMIT:    sitting_limit   = cfg_wdata[COUNT_W-1:0];
                    CFG_REPORT_INTERVAL:  report_interval = cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{state: m_occupancy_state, occupied: m_occupied, alarm: m_alarm_on,
                        seconds: m_seconds_sitting, taken: m_taken_flag};
                if (owed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status: state=%0d occ=%0b alarm=%0b secs=%0d flag=%0b",
                                 got.state, got.occupied, got.alarm, got.seconds, got.taken);
                end else begin
                    want = owed_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("status mismatch: want state=%0d occ=%0b alarm=%0b secs=%0d flag=%0b",
                                     want.state, want.occupied, want.alarm, want.seconds,
                                     want.taken);
                            $display("                  got state=%0d occ=%0b alarm=%0b secs=%0d flag=%0b",
                                     got.state, got.occupied, got.alarm, got.seconds,
                                     got.taken);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                owed_q.push_back(advance_monitor(s_func, s_present_sample));
        end
        mismatch_count <= mismatches;
        statuses_owed  <= owed_q.size();
    end

endmodule

### tb/occupancy_sitting_time_monitor_tb.sv
// Testbench top for the occupancy monitor: clock, reset, stimulus, settings and verdict.
module occupancy_sitting_time_monitor_tb;
    import ostm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         IDLE_PCT    = 35;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [1:0]         s_func           = FUNC_SAMPLE;
    logic               s_present_sample = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [1:0]         m_occupancy_state;
    logic               m_occupied;
    logic               m_alarm_on;
    logic [COUNT_W-1:0] m_seconds_sitting;
    logic               m_taken_flag;
    logic               cfg_we           = 1'b0;
    logic [1:0]         cfg_index        = CFG_PRESENCE_CONFIRM;
    logic [CFG_W-1:0]   cfg_wdata        = '0;

    int mismatch_count;
    int statuses_owed;
    int cycle_no = 0;
    bit calm     = 1'b0;

    occupancy_sitting_time_monitor uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_present_sample  (s_present_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_occupancy_state (m_occupancy_state),
        .m_occupied        (m_occupied),
        .m_alarm_on        (m_alarm_on),
        .m_seconds_sitting (m_seconds_sitting),
        .m_taken_flag      (m_taken_flag),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    occupancy_status_checker status_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_present_sample  (s_present_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_occupancy_state (m_occupancy_state),
        .m_occupied        (m_occupied),
        .m_alarm_on        (m_alarm_on),
        .m_seconds_sitting (m_seconds_sitting),
        .m_taken_flag      (m_taken_flag),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatch_count    (mismatch_count),
        .statuses_owed     (statuses_owed)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("FAIL occupancy_sitting_time_monitor");
            $finish;
        end
    end

    // Hold the item until it is accepted; idle gaps come first.
    task automatic send_item(logic [1:0] func, logic here);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= func;
        s_present_sample <= here;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (statuses_owed != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(logic [CFG_W-1:0] pres, logic [CFG_W-1:0] absn,
                                 logic [CFG_W-1:0] limit, logic [CFG_W-1:0] interval);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRESENCE_CONFIRM;
        cfg_wdata <= pres;
        @(posedge aclk);
        cfg_index <= CFG_ABSENCE_CONFIRM;
        cfg_wdata <= absn;
        @(posedge aclk);
        cfg_index <= CFG_SITTING_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_index <= CFG_REPORT_INTERVAL;
        cfg_wdata <= interval;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Runs of like samples with takes and unused functions mixed in; a few flipped samples act as noise.
    task automatic sample_runs(int count);
        int   sent;
        int   run_len;
        int   pick;
        logic here;
        sent = 0;
        here = 1'($urandom_range(0, 1));
        while (sent < count) begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            repeat (run_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_item(FUNC_TAKE_CHANGED, 1'($urandom_range(0, 1)));
                else if (pick < 20)
                    send_item(FUNC_TAKE_REPORT, 1'($urandom_range(0, 1)));
                else if (pick < 23)
                    send_item(FUNC_UNUSED, 1'($urandom_range(0, 1)));
                else if (pick < 27)
                    send_item(FUNC_SAMPLE, !here);
                else
                    send_item(FUNC_SAMPLE, here);
                sent++;
            end
            if ($urandom_range(0, 9) < 7)
                here = !here;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: nothing to take, then enter and leave once.
        send_item(FUNC_TAKE_CHANGED, 1'b0);
        send_item(FUNC_TAKE_REPORT, 1'b1);
        send_item(FUNC_UNUSED, 1'b1);
        repeat (3) send_item(FUNC_SAMPLE, 1'b1);
        send_item(FUNC_TAKE_CHANGED, 1'b1);
        repeat (5) send_item(FUNC_SAMPLE, 1'b0);
        drain();

        // Zero counts: confirm at once, alarm on first second, report always due.
        load_settings('0, '0, '0, '0);
        send_item(FUNC_SAMPLE, 1'b1);
        send_item(FUNC_TAKE_REPORT, 1'b0);
        send_item(FUNC_TAKE_REPORT, 1'b0);
        send_item(FUNC_SAMPLE, 1'b0);
        send_item(FUNC_TAKE_CHANGED, 1'b0);
        drain();

        // Lower the confirm counts below runs already built up.
        load_settings(32'd6, 32'd6, 32'd5, 32'd3);
        repeat (4) send_item(FUNC_SAMPLE, 1'b1);
        drain();
        load_settings(32'd2, 32'd6, 32'd5, 32'd3);
        send_item(FUNC_SAMPLE, 1'b1);
        repeat (4) send_item(FUNC_SAMPLE, 1'b0);
        drain();
        load_settings(32'd2, 32'd3, 32'd5, 32'd3);
        send_item(FUNC_SAMPLE, 1'b0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                2: load_settings('0, 32'h0000_FFFF, 32'hFFFF_FFFF, '0);
                5: load_settings(32'h0000_FFFF, '0, '0, 32'hFFFF_FFFF);
                7: load_settings(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: begin
                    // Upper bits on the 16-bit counts must be dropped.
                    load_settings({16'($urandom), 16'($urandom_range(0, 4))},
                                  {16'($urandom), 16'($urandom_range(0, 6))},
                                  $urandom_range(0, 40), $urandom_range(0, 15));
                end
            endcase
            calm = (phase == 3);
            sample_runs((phase == 5) ? 100 : 225);
            drain();
        end
        calm = 1'b0;

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && statuses_owed == 0)
            $display("PASS occupancy_sitting_time_monitor");
        else
            $display("FAIL occupancy_sitting_time_monitor");
        $finish;
    end

endmodule
